[rtl/tdphf_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and controller/datapath interface types for the touch
// delta peak-hold filter. No dependencies.
package tdphf_pkg;

    localparam int CHANNELS     = 16;
    localparam int WINDOW_DEPTH = 8;

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int WIN_W  = $clog2(WINDOW_DEPTH);
    localparam int ADDR_W = CH_W + WIN_W;
    localparam int MEM_DEPTH = 2 ** ADDR_W;

    localparam int DATA_W = 16;
    localparam int THR_W  = 16;
    localparam int PCT_W  = 7;
    localparam int MAG_W  = DATA_W + 1;
    // Wide enough for 100 * (magnitude + 1) and threshold * percent.
    localparam int CMP_W  = 24;

    localparam int PCT_SCALE  = 100;
    localparam logic [PCT_W-1:0] PCT_RESET = 7'd50;

    localparam int IN_TDATA_W = 40;
    localparam int CH_IN_W    = 4;

    typedef struct packed {
        logic              capture;
        logic              clear_rel;
        logic              decide;
        logic              wr_en;
        logic              rd_en;
        logic              clr_en;
        logic              load_out;
        logic [WIN_W-1:0]  idx;
        logic [ADDR_W-1:0] clr_addr;
    } cmd_t;

    typedef struct packed {
        logic active;
        logic fill;
    } sts_t;

endpackage

[rtl/touch_delta_peak_hold_filter_core.sv]
`timescale 1ns / 1ps
// Touch delta peak-hold filter top level; uses tdphf_pkg, tdphf_ctrl and tdphf_dp.
// A result comes soonest for an undetected sample, later for a detected one and last when a release
// rewrites the window (one RAM access per cycle: WINDOW_DEPTH reads for the maximum,
// WINDOW_DEPTH writes on release). One sample is in work at a time; the next is taken
// the cycle after its result is registered, which waits while the receiver stalls.
// Reset: a clearing pass over all MEM_DEPTH (128) words zeroes the window RAM first.
module touch_delta_peak_hold_filter_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // channel [3:0], delta [19:4], threshold [35:20], zero [39:36]
    input  logic [tdphf_pkg::IN_TDATA_W-1:0]  s_tdata,
    // touch_detected [0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // filtered_delta [15:0]
    output logic [tdphf_pkg::DATA_W-1:0]      m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tdphf_pkg::PCT_W-1:0]       cfg_data
);

    tdphf_pkg::cmd_t cmd;
    tdphf_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    tdphf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tdphf_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata)
    );

endmodule

[rtl/tdphf_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tdphf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/tdphf_dp.sv]
`timescale 1ns / 1ps
// Datapath of the peak-hold filter: sample registers, release compare, window
// RAM, running maximum and result register. Uses tdphf_pkg and tdphf_ram.
module tdphf_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  tdphf_pkg::cmd_t                   cmd,
    output tdphf_pkg::sts_t                   sts,
    input  logic [tdphf_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                              s_tuser,
    input  logic                              cfg_valid,
    input  logic [tdphf_pkg::PCT_W-1:0]       cfg_data,
    output logic [tdphf_pkg::DATA_W-1:0]      m_tdata
);

    logic [tdphf_pkg::PCT_W-1:0]  pct_reg;
    logic [tdphf_pkg::CH_W-1:0]   ch_reg;
    logic                         in_range_reg;
    logic signed [tdphf_pkg::DATA_W-1:0] delta_reg;
    logic                         det_reg;
    logic [tdphf_pkg::THR_W-1:0]  thr_reg;
    logic [tdphf_pkg::CMP_W-1:0]  lhs_reg, rhs_reg;
    logic [tdphf_pkg::CHANNELS-1:0] rel_reg, rel_next;
    logic                         fill_reg;
    logic [tdphf_pkg::WIN_W-1:0]  pos_reg, slot_reg;
    logic                         rd_vld_reg;
    logic signed [tdphf_pkg::DATA_W-1:0] max_reg;
    logic [tdphf_pkg::DATA_W-1:0] out_reg;

    logic [tdphf_pkg::CH_IN_W-1:0] s_channel;
    logic [tdphf_pkg::MAG_W-1:0]   mag;
    logic                          below;
    logic [tdphf_pkg::ADDR_W-1:0]  waddr, raddr;
    logic [tdphf_pkg::DATA_W-1:0]  wdata, rdata;
    logic [tdphf_pkg::WIN_W-1:0]   wr_idx;

    assign s_channel = s_tdata[3:0];

    assign mag = delta_reg[tdphf_pkg::DATA_W-1]
               ? tdphf_pkg::MAG_W'(-{delta_reg[tdphf_pkg::DATA_W-1], delta_reg})
               : tdphf_pkg::MAG_W'(delta_reg);

    // mag < floor(thr * pct / 100) is the same as 100 * (mag + 1) <= thr * pct.
    assign below = (lhs_reg <= rhs_reg);

    always_comb begin
        rel_next = rel_reg;
        if (cmd.clear_rel && in_range_reg) begin
            rel_next[ch_reg] = 1'b0;
        end else if (cmd.decide) begin
            rel_next[ch_reg] = below && !rel_reg[ch_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pct_reg    <= tdphf_pkg::PCT_RESET;
            rel_reg    <= '0;
            pos_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                pct_reg <= cfg_data;
            end
            rel_reg    <= rel_next;
            rd_vld_reg <= cmd.rd_en;
            if (cmd.decide) begin
                pos_reg <= (pos_reg == tdphf_pkg::WIN_W'(tdphf_pkg::WINDOW_DEPTH - 1))
                         ? '0 : pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            ch_reg       <= tdphf_pkg::CH_W'(s_channel);
            in_range_reg <= (int'(s_channel) < tdphf_pkg::CHANNELS);
            delta_reg    <= s_tdata[19:4];
            thr_reg      <= s_tdata[35:20];
            det_reg      <= s_tuser;
        end
        lhs_reg <= tdphf_pkg::CMP_W'(mag) * tdphf_pkg::CMP_W'(tdphf_pkg::PCT_SCALE)
                 + tdphf_pkg::CMP_W'(tdphf_pkg::PCT_SCALE);
        rhs_reg <= tdphf_pkg::CMP_W'(thr_reg) * tdphf_pkg::CMP_W'(pct_reg);
        if (cmd.decide) begin
            fill_reg <= below && rel_reg[ch_reg];
            slot_reg <= pos_reg;
            max_reg  <= '0;
        end else if (rd_vld_reg && ($signed(rdata) > max_reg)) begin
            max_reg <= $signed(rdata);
        end
        if (cmd.load_out) begin
            out_reg <= (det_reg && in_range_reg) ? max_reg : delta_reg;
        end
    end

    assign wr_idx = fill_reg ? cmd.idx : slot_reg;
    assign waddr  = cmd.clr_en ? cmd.clr_addr : {ch_reg, wr_idx};
    assign wdata  = cmd.clr_en ? '0 : delta_reg;
    assign raddr  = {ch_reg, cmd.idx};

    tdphf_ram #(
        .WIDTH (tdphf_pkg::DATA_W),
        .DEPTH (tdphf_pkg::MEM_DEPTH)
    ) u_window (
        .aclk  (aclk),
        .we    (cmd.wr_en || cmd.clr_en),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign sts.active = det_reg && in_range_reg;
    assign sts.fill   = fill_reg;
    assign m_tdata    = out_reg;

endmodule

[rtl/tdphf_ctrl.sv]
`timescale 1ns / 1ps
// Controller of the peak-hold filter: clearing pass, per-sample sequencing of
// the window RAM and the output handshake. Uses tdphf_pkg.
module tdphf_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  tdphf_pkg::sts_t sts,
    output tdphf_pkg::cmd_t cmd
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_WRITE  = 3'd4;
    localparam logic [2:0] ST_READ   = 3'd5;
    localparam logic [2:0] ST_DRAIN  = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    localparam logic [tdphf_pkg::WIN_W-1:0] K_LAST =
        tdphf_pkg::WIN_W'(tdphf_pkg::WINDOW_DEPTH - 1);

    logic [2:0]                      state_reg, state_next;
    logic [tdphf_pkg::WIN_W-1:0]     k_reg, k_next;
    logic [tdphf_pkg::ADDR_W-1:0]    clr_reg, clr_next;
    logic                            m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        clr_next   = clr_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_en   = 1'b1;
                cmd.clr_addr = clr_reg;
                clr_next     = clr_reg + 1'b1;
                if (&clr_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL: begin
                if (sts.active) begin
                    state_next = ST_DECIDE;
                end else begin
                    cmd.clear_rel = 1'b1;
                    state_next    = ST_OUT;
                end
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                k_next     = '0;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                // A release rewrites every slot of the channel, else one slot.
                cmd.wr_en = 1'b1;
                cmd.idx   = k_reg;
                if (!sts.fill || k_reg == K_LAST) begin
                    k_next     = '0;
                    state_next = ST_READ;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_READ: begin
                cmd.rd_en = 1'b1;
                cmd.idx   = k_reg;
                k_next    = k_reg + 1'b1;
                if (k_reg == K_LAST) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            k_reg        <= '0;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    a_ram_ops_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.wr_en, cmd.rd_en, cmd.clr_en}))
        else $error("window RAM write, read and clear overlap");

    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction accepted while a sample is in work");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over an untaken result");

    a_clear_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !s_tready && !m_tvalid_reg)
        else $error("handshake active during the clearing pass");

endmodule

[sim/tdphf_peak_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the touch delta peak-hold filter: watches the sample, result and
// register channels, predicts every filtered delta and compares. Uses tdphf_pkg.
module tdphf_peak_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // channel [3:0], delta [19:4], threshold [35:20], zero [39:36]
    input  logic [tdphf_pkg::IN_TDATA_W-1:0] s_tdata,
    // touch_detected [0]
    input  logic                             s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // filtered_delta [15:0]
    input  logic [tdphf_pkg::DATA_W-1:0]     m_tdata,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [tdphf_pkg::PCT_W-1:0]      cfg_data,
    output int                               mismatches,
    output int                               outstanding
);
    import tdphf_pkg::*;

    logic signed [DATA_W-1:0] history [CHANNELS][WINDOW_DEPTH];
    int unsigned              wr_slot;
    bit                       release_armed [CHANNELS];
    logic [PCT_W-1:0]         release_pct;
    logic [DATA_W-1:0]        filtered_q [$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    // Updates the window and release state of the channel and returns the filtered delta.
    function automatic logic [DATA_W-1:0] filter_sample(
        input logic [CH_IN_W-1:0]      ch,
        input logic signed [DATA_W-1:0] delta,
        input logic                     touched,
        input logic [THR_W-1:0]         thr
    );
        logic signed [MAG_W-1:0] wide;
        logic [MAG_W-1:0]        mag;
        logic [31:0]             level;
        logic signed [DATA_W-1:0] peak;
        if (ch >= CHANNELS)
            return delta;
        if (!touched) begin
            release_armed[ch] = 1'b0;
            return delta;
        end
        history[ch][wr_slot] = delta;
        wr_slot = (wr_slot + 1) % WINDOW_DEPTH;

        // The magnitude needs 17 bits so that the most negative delta does not wrap.
        wide  = MAG_W'(delta);
        mag   = (wide < 0) ? -wide : wide;
        level = (32'(thr) * 32'(release_pct)) / PCT_SCALE;
        if (32'(mag) < level) begin
            if (release_armed[ch]) begin
                release_armed[ch] = 1'b0;
                for (int k = 0; k < WINDOW_DEPTH; k++)
                    history[ch][k] = delta;
            end else begin
                release_armed[ch] = 1'b1;
            end
        end else begin
            release_armed[ch] = 1'b0;
        end

        peak = '0;
        for (int k = 0; k < WINDOW_DEPTH; k++)
            if (history[ch][k] > peak)
                peak = history[ch][k];
        return peak;
    endfunction

    always @(posedge aclk) begin : track
        logic [DATA_W-1:0] want;
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                release_armed[c] = 1'b0;
                for (int k = 0; k < WINDOW_DEPTH; k++)
                    history[c][k] = '0;
            end
            wr_slot     = 0;
            release_pct = PCT_RESET;
            filtered_q.delete();
            outstanding = 0;
        end else begin
            // A result always belongs to an earlier sample, so it is retired first.
            if (m_tvalid && m_tready) begin
                if (filtered_q.size() == 0) begin
                    $display("%0t: filtered_delta expected none, actual %0d",
                             $time, $signed(m_tdata));
                    mismatches++;
                end else begin
                    want = filtered_q.pop_front();
                    if (m_tdata !== want) begin
                        $display("%0t: filtered_delta expected %0d, actual %0d",
                                 $time, $signed(want), $signed(m_tdata));
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                release_pct = cfg_data;
            if (s_tvalid && s_tready)
                filtered_q.push_back(filter_sample(s_tdata[3:0], s_tdata[19:4], s_tuser,
                                                   s_tdata[35:20]));
            outstanding = filtered_q.size();
        end
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for the touch delta peak-hold filter: clock, reset, sample and
// register stimulus, receiver stalls and verdict. Uses tdphf_pkg, tdphf_peak_checker.
module tb_top;
    import tdphf_pkg::*;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int HOLD_CYCLES      = 300;
    localparam int SETTLE_CYCLES    = 30;
    localparam int RANDOM_PER_PHASE = 100;
    localparam int PHASES           = 8;
    localparam int HOLD_PHASE       = 2;

    logic                    aclk;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata   = '0;
    logic                    s_tuser   = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [DATA_W-1:0]       m_tdata;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [PCT_W-1:0]        cfg_data  = '0;

    int mismatches;
    int outstanding;
    int cycles     = 0;
    int burst_left = 0;
    bit hold_req   = 1'b0;

    touch_delta_peak_hold_filter_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    tdphf_peak_checker u_peak_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: alternating ready and stall runs, plus one long hold-off on request.
    initial begin : receiver
        int run_left;
        bit ready_now;
        run_left  = 0;
        ready_now = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                run_left = 0;
            end else begin
                if (run_left == 0) begin
                    ready_now = !ready_now;
                    run_left  = ready_now ? $urandom_range(1, 40) : $urandom_range(1, 6);
                end
                run_left--;
                m_tready <= ready_now;
            end
        end
    end

    // Sender pacing: bursts of random length separated by random gaps.
    task automatic next_gap();
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
    endtask

    task automatic push_sample(input logic [3:0] ch, input logic [15:0] delta,
                               input logic touched, input logic [15:0] thr);
        next_gap();
        s_tdata  <= {4'd0, thr, delta, ch};
        s_tuser  <= touched;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic set_release_percent(input logic [PCT_W-1:0] pct);
        cfg_data  <= pct;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Mostly runs of small deltas near the release level on a few channels, so that
    // release sequences happen often; the rest is unrestricted noise and extremes.
    task automatic random_sample();
        logic [3:0]  ch;
        logic [15:0] mag;
        logic [15:0] delta;
        logic [15:0] thr;
        logic        touched;
        int          pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            ch      = 4'($urandom_range(0, 3));
            thr     = 16'($urandom_range(0, 4000));
            mag     = 16'($urandom_range(0, 2200));
            delta   = $urandom_range(0, 1) ? -mag : mag;
            touched = ($urandom_range(0, 15) != 0);
        end else if (pick < 8) begin
            ch      = 4'($urandom);
            delta   = 16'($urandom);
            thr     = 16'($urandom);
            touched = 1'($urandom_range(0, 1));
        end else begin
            ch = 4'($urandom);
            case ($urandom_range(0, 3))
                0: delta = 16'h8000;
                1: delta = 16'h7FFF;
                2: delta = 16'h0000;
                default: delta = 16'hFFFF;
            endcase
            case ($urandom_range(0, 2))
                0: thr = 16'h0000;
                1: thr = 16'hFFFF;
                default: thr = 16'($urandom);
            endcase
            touched = ($urandom_range(0, 3) != 0);
        end
        push_sample(ch, delta, touched, thr);
    endtask

    initial begin : stimulus
        int pct_plan [PHASES];
        pct_plan = '{0, 100, 1, 99, 27, 0, 0, 50};
        pct_plan[5] = $urandom_range(0, 100);
        pct_plan[6] = $urandom_range(0, 100);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, release level at its reset value of 50 percent.
        push_sample(4'd0,  16'h8000, 1'b0, 16'h0000);
        push_sample(4'd15, 16'h7FFF, 1'b0, 16'hFFFF);
        push_sample(4'd0,  16'h7FFF, 1'b1, 16'h0000);
        push_sample(4'd1,  16'h8000, 1'b1, 16'hFFFF);
        push_sample(4'd1,  16'h8000, 1'b1, 16'hFFFF);
        push_sample(4'd3,  -16'sd100, 1'b1, 16'd0);
        push_sample(4'd2,  -16'sd5,  1'b1, 16'd100);
        push_sample(4'd2,  16'd7,    1'b1, 16'd100);
        push_sample(4'd2,  16'd50,   1'b1, 16'd100);
        push_sample(4'd2,  -16'sd3,  1'b1, 16'd100);
        push_sample(4'd2,  -16'sd3,  1'b0, 16'd100);
        push_sample(4'd2,  16'd20,   1'b1, 16'd100);
        push_sample(4'd2,  16'd60,   1'b1, 16'd100);
        push_sample(4'd2,  16'd10,   1'b1, 16'd100);
        push_sample(4'd5,  16'd10,   1'b1, 16'd100);
        push_sample(4'd2,  16'd12,   1'b1, 16'd100);
        push_sample(4'd14, 16'h7FFF, 1'b1, 16'hFFFF);
        push_sample(4'd14, 16'hFFFF, 1'b1, 16'hFFFF);
        push_sample(4'd14, 16'h8001, 1'b1, 16'hFFFF);
        push_sample(4'd9,  16'h8000, 1'b1, 16'h0000);
        drain_results();

        for (int p = 0; p < PHASES; p++) begin
            set_release_percent(PCT_W'(pct_plan[p]));
            // The block holds one sample at a time, so this stalls the input quickly.
            if (p == HOLD_PHASE)
                hold_req = 1'b1;
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
                random_sample();
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
